// File: design/kr_pkg.sv
// Shared types and constants for the keyed record table.
// Record layout, per-cell control, action, status and FSM codes.
// Has no dependencies; the top level and kr_cell use it.
package kr_pkg;

  localparam int KEY_W = 20;
  localparam int SAL_W = 31;
  localparam int DEP_W = 16;
  localparam int ACT_W = 3;
  localparam int STS_W = 3;
  localparam int POS_W = 6;

  localparam logic [KEY_W-1:0] KEY_MAX = '1;
  localparam logic [KEY_W-1:0] KEY_FIRST = KEY_W'(1);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [SAL_W-1:0] salary;
    logic [DEP_W-1:0] department;
  } kr_rec_t;

  // Per-cell write controls; at most one of them is set in a cycle.
  typedef struct packed {
    logic load;   // take the whole new record
    logic upd;    // take salary and department of the new record
    logic shift;  // take the record of the next cell up
  } kr_cell_ctrl_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD   = 3'd0,
    ACT_ADD    = 3'd1,
    ACT_UPDATE = 3'd2,
    ACT_DELETE = 3'd3,
    ACT_READ   = 3'd4
  } kr_action_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK           = 3'd0,
    STS_NOT_FOUND    = 3'd1,
    STS_INVALID_KEY  = 3'd2,
    STS_FULL         = 3'd3,
    STS_BAD_POSITION = 3'd4,
    STS_KEY_OVERFLOW = 3'd5
  } kr_status_t;

  typedef enum logic {
    S_IDLE,
    S_APPLY
  } kr_state_t;

endpackage

// File: design/keyed_record_table_core.sv
// Keyed record table, top level.
// Built from kr_cell (one per entry) and kr_pick; types from kr_pkg.
//
// The table keeps up to TABLE_DEPTH records in insertion order in a row of
// cells, one record per cell, and performs one action per input transfer:
// load, add with automatic key, update, delete with compaction, or read by
// position; other codes only report OK. Each transfer produces exactly one
// result transfer. In the accept cycle every cell compares its key with the
// incoming key in parallel and the match vector is registered; in the apply
// state the first match is isolated, the selected record is read out, and
// the write, payload update or one-step downward shift of the match cell and
// all cells above it is applied while the result is loaded into the output
// register. The output register lets the next item be accepted while a
// result still waits; the apply state waits only if the previous result has
// not yet been taken. The table needs no clearing pass after reset: cells at
// or above the entry count are never read.
module keyed_record_table_core #(
  parameter int TABLE_DEPTH = 64,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [kr_pkg::ACT_W-1:0]    in_action,
  input  logic [kr_pkg::KEY_W-1:0]    in_key,
  input  logic [kr_pkg::SAL_W-1:0]    in_salary,
  input  logic [kr_pkg::DEP_W-1:0]    in_department,
  input  logic [kr_pkg::POS_W-1:0]    in_position,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [kr_pkg::STS_W-1:0]    out_status,
  output logic [kr_pkg::KEY_W-1:0]    out_result_key,
  output logic [kr_pkg::SAL_W-1:0]    out_result_salary,
  output logic [kr_pkg::DEP_W-1:0]    out_result_department,
  output logic [CNT_W-1:0]            out_entry_total
);

  // Width wide enough to compare a position against the entry count.
  localparam int CMP_W = (CNT_W > kr_pkg::POS_W) ? CNT_W : kr_pkg::POS_W;

  kr_pkg::kr_state_t state_r, state_nxt;

  // Accepted item.
  logic [kr_pkg::ACT_W-1:0] act_r;
  logic [kr_pkg::KEY_W-1:0] key_r;
  logic [kr_pkg::SAL_W-1:0] sal_r;
  logic [kr_pkg::DEP_W-1:0] dep_r;
  logic [kr_pkg::POS_W-1:0] pos_r;

  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [TABLE_DEPTH-1:0] match_r, match_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt;
  kr_pkg::kr_status_t       out_status_r, out_status_nxt;
  kr_pkg::kr_rec_t          out_rec_r, out_rec_nxt;
  logic [CNT_W-1:0]         out_total_r;

  // Cell row.
  kr_pkg::kr_cell_ctrl_t ctrl     [TABLE_DEPTH];
  kr_pkg::kr_rec_t       rec_q    [TABLE_DEPTH];
  kr_pkg::kr_rec_t       nbr_rec  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] key_eq;

  logic [TABLE_DEPTH-1:0] first_oh;
  logic [TABLE_DEPTH-1:0] at_or_above;
  logic [TABLE_DEPTH-1:0] pos_oh;
  logic [TABLE_DEPTH-1:0] last_oh;
  logic [TABLE_DEPTH-1:0] app_oh;
  logic [TABLE_DEPTH-1:0] sel_oh;

  kr_pkg::kr_rec_t        sel_rec;
  kr_pkg::kr_rec_t        new_rec;
  logic [kr_pkg::KEY_W-1:0] auto_key;

  logic accept_in;
  logic out_free;
  logic found;
  logic full;
  logic pos_ok;
  logic do_load;
  logic do_upd;
  logic do_shift;

  assign accept_in = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != kr_pkg::S_IDLE);

  assign found  = |match_r;
  assign full   = (count_r == CNT_W'(TABLE_DEPTH));
  assign pos_ok = (CMP_W'(pos_r) < CMP_W'(count_r));

  // The search key is the incoming key: the compare runs in the accept cycle.
  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == TABLE_DEPTH - 1) begin : g_top
        assign nbr_rec[gi] = rec_q[gi];
      end else begin : g_mid
        assign nbr_rec[gi] = rec_q[gi + 1];
      end

      assign pos_oh[gi]  = (CMP_W'(gi) == CMP_W'(pos_r));
      assign last_oh[gi] = (CNT_W'(gi + 1) == count_r);
      assign app_oh[gi]  = (CNT_W'(gi) == count_r);

      assign ctrl[gi].load  = do_load  && app_oh[gi];
      assign ctrl[gi].upd   = do_upd   && first_oh[gi];
      assign ctrl[gi].shift = do_shift && at_or_above[gi];

      kr_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl[gi]),
        .new_rec (new_rec),
        .nbr_rec (nbr_rec[gi]),
        .cmp_key (in_key),
        .rec_q   (rec_q[gi]),
        .key_eq  (key_eq[gi])
      );
    end
  endgenerate

  kr_pick #(
    .N (TABLE_DEPTH)
  ) u_pick (
    .match       (match_r),
    .first_oh    (first_oh),
    .at_or_above (at_or_above)
  );

  // Only cells below the entry count take part in a search.
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      match_nxt[i] = key_eq[i] && (CNT_W'(i) < count_r);
    end
  end

  // The record to report comes from one cell, chosen by the action.
  always_comb begin
    case (kr_pkg::kr_action_t'(act_r))
      kr_pkg::ACT_ADD:    sel_oh = last_oh;
      kr_pkg::ACT_READ:   sel_oh = pos_oh;
      default:            sel_oh = first_oh;
    endcase
  end

  always_comb begin
    sel_rec = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (sel_oh[i]) begin
        sel_rec = kr_pkg::kr_rec_t'(sel_rec | rec_q[i]);
      end
    end
  end

  // An empty table starts automatic keys at one.
  assign auto_key = (count_r == '0) ? kr_pkg::KEY_FIRST : (sel_rec.key + kr_pkg::KEY_W'(1));

  // Next state, cell controls and result.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_rec_nxt    = out_rec_r;
    do_load        = 1'b0;
    do_upd         = 1'b0;
    do_shift       = 1'b0;
    new_rec.key        = key_r;
    new_rec.salary     = sal_r;
    new_rec.department = dep_r;

    case (state_r)
      kr_pkg::S_IDLE: begin
        if (accept_in) begin
          state_nxt = kr_pkg::S_APPLY;
        end
      end
      kr_pkg::S_APPLY: begin
        if (out_free) begin
          state_nxt      = kr_pkg::S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = kr_pkg::STS_OK;
          out_rec_nxt    = '0;
          case (kr_pkg::kr_action_t'(act_r))
            kr_pkg::ACT_LOAD: begin
              if (full) begin
                out_status_nxt = kr_pkg::STS_FULL;
              end else begin
                do_load     = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
                out_rec_nxt = new_rec;
              end
            end
            kr_pkg::ACT_ADD: begin
              new_rec.key = auto_key;
              if (full) begin
                out_status_nxt = kr_pkg::STS_FULL;
              end else if (count_r != '0 && sel_rec.key == kr_pkg::KEY_MAX) begin
                out_status_nxt = kr_pkg::STS_KEY_OVERFLOW;
              end else begin
                do_load     = 1'b1;
                count_nxt   = count_r + CNT_W'(1);
                out_rec_nxt = new_rec;
              end
            end
            kr_pkg::ACT_UPDATE: begin
              if (!found) begin
                out_status_nxt = kr_pkg::STS_NOT_FOUND;
              end else begin
                do_upd      = 1'b1;
                out_rec_nxt = new_rec;
              end
            end
            kr_pkg::ACT_DELETE: begin
              // Key zero is refused only once a match exists.
              if (!found) begin
                out_status_nxt = kr_pkg::STS_NOT_FOUND;
              end else if (key_r == '0) begin
                out_status_nxt = kr_pkg::STS_INVALID_KEY;
              end else begin
                do_shift    = 1'b1;
                count_nxt   = count_r - CNT_W'(1);
                out_rec_nxt = sel_rec;
              end
            end
            kr_pkg::ACT_READ: begin
              if (!pos_ok) begin
                out_status_nxt = kr_pkg::STS_BAD_POSITION;
              end else begin
                out_rec_nxt = sel_rec;
              end
            end
            default: begin
              out_status_nxt = kr_pkg::STS_OK;
            end
          endcase
        end
      end
      default: begin
        state_nxt = kr_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kr_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      act_r   <= in_action;
      key_r   <= in_key;
      sal_r   <= in_salary;
      dep_r   <= in_department;
      pos_r   <= in_position;
      match_r <= match_nxt;
    end
    if (state_r == kr_pkg::S_APPLY && out_free) begin
      out_status_r <= out_status_nxt;
      out_rec_r    <= out_rec_nxt;
      out_total_r  <= count_nxt;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_result_key        = out_rec_r.key;
  assign out_result_salary     = out_rec_r.salary;
  assign out_result_department = out_rec_r.department;
  assign out_entry_total       = out_total_r;

endmodule

// File: design/kr_cell.sv
// One table cell: holds one record and compares its key with a search key.
// Uses kr_pkg for the record and control types.
module kr_cell (
  input  logic                          clk,
  input  kr_pkg::kr_cell_ctrl_t         ctrl,
  input  kr_pkg::kr_rec_t               new_rec,
  input  kr_pkg::kr_rec_t               nbr_rec,
  input  logic [kr_pkg::KEY_W-1:0]      cmp_key,
  output kr_pkg::kr_rec_t               rec_q,
  output logic                          key_eq
);

  kr_pkg::kr_rec_t rec_r;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rec_r <= new_rec;
    end else if (ctrl.upd) begin
      rec_r.salary     <= new_rec.salary;
      rec_r.department <= new_rec.department;
    end else if (ctrl.shift) begin
      rec_r <= nbr_rec;
    end
  end

  assign rec_q  = rec_r;
  assign key_eq = (rec_r.key == cmp_key);

endmodule

// File: design/kr_pick.sv
// First-match picker: isolates the lowest set match bit and marks every
// cell at or above it. Has no dependencies.
module kr_pick #(
  parameter int N = 64
) (
  input  logic [N-1:0] match,
  output logic [N-1:0] first_oh,
  output logic [N-1:0] at_or_above
);

  logic [N-1:0] low_run;

  // Two's complement isolates the lowest set bit.
  assign first_oh    = match & (~match + N'(1));
  // match ^ (match - 1) covers the lowest set bit and everything below it.
  assign low_run     = match ^ (match - N'(1));
  assign at_or_above = ~low_run | first_oh;

endmodule
